FILE: hw/rtl/lfukvc_pkg.sv
// Shared types and constants for the LFU key-value cache.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package lfukvc_pkg;

  localparam int MAX_ENTRIES = 16;
  localparam int WORD_W      = 32;
  localparam int COUNT_W     = 16;
  localparam int STAMP_W     = 64;
  localparam int CAP_W       = 5;
  localparam int CAP_RESET   = 16;
  localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int FILL_W      = $clog2(MAX_ENTRIES + 1);
  localparam int CMP_W       = (CAP_W > FILL_W) ? CAP_W : FILL_W;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  typedef enum logic {
    OP_GET = 1'b0,
    OP_PUT = 1'b1
  } opcode_t;

  typedef logic [IDX_W-1:0]   idx_t;
  typedef logic [WORD_W-1:0]  word_t;
  typedef logic [COUNT_W-1:0] count_t;
  typedef logic [STAMP_W-1:0] stamp_t;

  typedef struct packed {
    logic   valid;
    word_t  key;
    word_t  value;
    count_t count;
    stamp_t stamp;
  } entry_t;

  typedef struct packed {
    logic   en;
    idx_t   addr;
    entry_t data;
  } entry_wr_t;

  typedef struct packed {
    logic   found;
    idx_t   found_idx;
    word_t  found_value;
    count_t found_count;
    logic   have_best;
    idx_t   best_idx;
    logic   have_free;
    idx_t   free_idx;
  } scan_res_t;

endpackage

`default_nettype wire

FILE: hw/rtl/lfukvc_if.sv
// Request and response channel interfaces of the LFU key-value cache.
// Depends on lfukvc_pkg for the field widths.
`default_nettype none

interface lfukvc_req_if;
  import lfukvc_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     opcode;
  logic signed [WORD_W-1:0] lookup_key;
  logic signed [WORD_W-1:0] write_value;

  modport source (output valid, output opcode, output lookup_key, output write_value,
                  input ready);
  modport sink   (input valid, input opcode, input lookup_key, input write_value,
                  output ready);
endinterface

interface lfukvc_rsp_if;
  import lfukvc_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     hit;
  logic signed [WORD_W-1:0] read_value;
  logic                     evicted;

  modport source (output valid, output hit, output read_value, output evicted,
                  input ready);
  modport sink   (input valid, input hit, input read_value, input evicted,
                  output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/lfukvc_table.sv
// Entry table: valid bits, keys, values, use counts and access stamps.
// One registered read port, one write port. Depends on lfukvc_pkg.
`default_nettype none

module lfukvc_table (
  input  logic                  clk,
  input  logic                  rst,
  input  lfukvc_pkg::idx_t      rd_addr,
  output lfukvc_pkg::entry_t    rd_data,
  input  lfukvc_pkg::entry_wr_t wr
);
  import lfukvc_pkg::*;

  logic [MAX_ENTRIES-1:0] valid;
  word_t                  key_mem   [MAX_ENTRIES];
  word_t                  value_mem [MAX_ENTRIES];
  count_t                 count_mem [MAX_ENTRIES];
  stamp_t                 stamp_mem [MAX_ENTRIES];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wr.en) begin
      valid[wr.addr] <= wr.data.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en) begin
      key_mem[wr.addr]   <= wr.data.key;
      value_mem[wr.addr] <= wr.data.value;
      count_mem[wr.addr] <= wr.data.count;
      stamp_mem[wr.addr] <= wr.data.stamp;
    end
  end

  always_ff @(posedge clk) begin
    rd_data.valid <= valid[rd_addr];
    rd_data.key   <= key_mem[rd_addr];
    rd_data.value <= value_mem[rd_addr];
    rd_data.count <= count_mem[rd_addr];
    rd_data.stamp <= stamp_mem[rd_addr];
  end

endmodule

`default_nettype wire

FILE: hw/rtl/lfukvc_scan.sv
// Shared compare unit: one entry per beat of the scan, tracking key match,
// eviction victim and first free slot. Depends on lfukvc_pkg.
`default_nettype none

module lfukvc_scan (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  clear,
  input  logic                  step,
  input  lfukvc_pkg::idx_t      idx,
  input  lfukvc_pkg::entry_t    entry,
  input  lfukvc_pkg::word_t     search_key,
  output lfukvc_pkg::scan_res_t res
);
  import lfukvc_pkg::*;

  count_t best_count;
  stamp_t best_stamp;
  logic   key_eq;
  logic   better;

  assign key_eq = entry.valid && (entry.key == search_key);
  assign better = entry.valid &&
                  (!res.have_best ||
                   (entry.count < best_count) ||
                   ((entry.count == best_count) && (entry.stamp < best_stamp)));

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      res.found     <= 1'b0;
      res.have_best <= 1'b0;
      res.have_free <= 1'b0;
    end else if (step) begin
      if (key_eq && !res.found) begin
        res.found       <= 1'b1;
        res.found_idx   <= idx;
        res.found_value <= entry.value;
        res.found_count <= entry.count;
      end
      if (better) begin
        res.have_best <= 1'b1;
        res.best_idx  <= idx;
        best_count    <= entry.count;
        best_stamp    <= entry.stamp;
      end
      if (!entry.valid && !res.have_free) begin
        res.have_free <= 1'b1;
        res.free_idx  <= idx;
      end
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/lfu_key_value_cache_top.sv
// LFU key-value cache: a fully associative table of MAX_ENTRIES entries with
// least-frequently-used replacement, oldest access breaking ties. Each request
// beat is taken in the idle state, then every entry is scanned through the
// shared compare unit, then the entry is written back and the response register
// loaded. req.ready is high only while the sequencer is idle; a response waiting
// in its register does not block the next request until that request reaches
// its write-back. No clearing pass.
// Depends on lfukvc_pkg, lfukvc_if, lfukvc_table and lfukvc_scan.
`default_nettype none

module lfu_key_value_cache_top (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  logic [lfukvc_pkg::CAP_W-1:0] cfg_wdata,
  lfukvc_req_if.sink              req,
  lfukvc_rsp_if.source            rsp
);
  import lfukvc_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_WRITE
  } state_t;

  localparam idx_t LAST_IDX = IDX_W'(MAX_ENTRIES - 1);

  state_t            state;
  idx_t              idx;
  idx_t              rd_addr;
  logic              item_op;
  word_t             item_key;
  word_t             item_val;
  logic [CAP_W-1:0]  cap;
  logic [FILL_W-1:0] filled;
  stamp_t            access_clock;

  logic              out_valid;
  logic              out_hit;
  word_t             out_value;
  logic              out_evicted;

  entry_t            rd_entry;
  entry_wr_t         wr;
  scan_res_t         res;

  logic              accept;
  logic              commit;
  logic [CMP_W-1:0]  cap_eff;
  logic              fill_inc;
  logic              rd_hit;
  word_t             rd_value;
  logic              rd_evicted;
  count_t            count_inc;

  assign accept = req.valid && req.ready;
  assign commit = (state == S_WRITE) && (!out_valid || rsp.ready);
  assign cap_eff = (CMP_W'(cap) > CMP_W'(MAX_ENTRIES)) ? CMP_W'(MAX_ENTRIES) : CMP_W'(cap);
  assign count_inc = (res.found_count == COUNT_MAX) ? COUNT_MAX
                                                    : res.found_count + COUNT_W'(1);

  // fetch one entry ahead of the compare
  assign rd_addr = (state == S_SCAN) ? idx + IDX_W'(1) : '0;

  assign req.ready      = (state == S_IDLE);
  assign rsp.valid      = out_valid;
  assign rsp.hit        = out_hit;
  assign rsp.read_value = out_value;
  assign rsp.evicted    = out_evicted;

  lfukvc_table u_table (
    .clk     (clk),
    .rst     (rst),
    .rd_addr (rd_addr),
    .rd_data (rd_entry),
    .wr      (wr)
  );

  lfukvc_scan u_scan (
    .clk        (clk),
    .rst        (rst),
    .clear      (accept),
    .step       (state == S_SCAN),
    .idx        (idx),
    .entry      (rd_entry),
    .search_key (item_key),
    .res        (res)
  );

  always_comb begin
    wr         = '0;
    fill_inc   = 1'b0;
    rd_hit     = res.found;
    rd_value   = '0;
    rd_evicted = 1'b0;
    wr.data.valid = 1'b1;
    wr.data.key   = item_key;
    wr.data.stamp = access_clock;
    if (item_op == OP_GET) begin
      if (res.found) begin
        rd_value      = res.found_value;
        wr.en         = 1'b1;
        wr.addr       = res.found_idx;
        wr.data.value = res.found_value;
        wr.data.count = count_inc;
      end else begin
        rd_value = '1;
      end
    end else if (cap_eff != '0) begin
      wr.data.value = item_val;
      if (res.found) begin
        wr.en         = 1'b1;
        wr.addr       = res.found_idx;
        wr.data.count = count_inc;
      end else begin
        wr.data.count = COUNT_W'(1);
        if ((CMP_W'(filled) >= cap_eff) || !res.have_free) begin
          wr.en      = res.have_best;
          wr.addr    = res.best_idx;
          rd_evicted = res.have_best;
        end else begin
          wr.en    = 1'b1;
          wr.addr  = res.free_idx;
          fill_inc = 1'b1;
        end
      end
    end
    if (!commit) begin
      wr.en      = 1'b0;
      fill_inc   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      idx          <= '0;
      cap          <= CAP_W'(CAP_RESET);
      filled       <= '0;
      access_clock <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_we) begin
        cap <= cfg_wdata;
      end
      if (out_valid && rsp.ready && !commit) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            item_op  <= req.opcode;
            item_key <= req.lookup_key;
            item_val <= req.write_value;
            idx      <= '0;
            state    <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (idx == LAST_IDX) begin
            state <= S_WRITE;
          end else begin
            idx <= idx + IDX_W'(1);
          end
        end
        S_WRITE: begin
          if (commit) begin
            out_valid   <= 1'b1;
            out_hit     <= rd_hit;
            out_value   <= rd_value;
            out_evicted <= rd_evicted;
            if (wr.en) begin
              access_clock <= access_clock + STAMP_W'(1);
            end
            if (fill_inc) begin
              filled <= filled + FILL_W'(1);
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> !req.ready)
    else $error("request taken while a beat is in flight");

  a_rsp_from_writeback: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp.valid) |-> $past(state) == S_WRITE)
    else $error("response raised outside write-back");

  a_evict_not_hit: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.evicted |-> !rsp.hit && rsp.read_value == '0)
    else $error("eviction reported with hit or read data");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    CMP_W'(filled) <= CMP_W'(MAX_ENTRIES))
    else $error("fill count beyond table size");

endmodule

`default_nettype wire

FILE: tb/tb_lfu_key_value_cache_top.sv
// Self-checking testbench for lfu_key_value_cache_top: drives get and put beats,
// predicts each response with its own LFU table and checks every response beat.
// Depends on lfukvc_pkg, lfukvc_if and the cache RTL.
`timescale 1ns / 100ps

module tb_lfu_key_value_cache_top;
  import lfukvc_pkg::*;

  typedef struct {
    opcode_t op;
    word_t   key;
    word_t   value;
  } access_t;

  typedef struct {
    logic  hit;
    word_t value;
    logic  evicted;
  } outcome_t;

  logic             clk;
  logic             rst;
  logic             cfg_we;
  logic [CAP_W-1:0] cfg_wdata;

  lfukvc_req_if req ();
  lfukvc_rsp_if rsp ();

  lfu_key_value_cache_top dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .req      (req),
    .rsp      (rsp)
  );

  // Shadow of the cache table
  logic             shadow_valid [MAX_ENTRIES];
  word_t            shadow_key   [MAX_ENTRIES];
  word_t            shadow_value [MAX_ENTRIES];
  count_t           shadow_count [MAX_ENTRIES];
  stamp_t           shadow_stamp [MAX_ENTRIES];
  stamp_t           shadow_clock;
  int unsigned      shadow_fill;
  logic [CAP_W-1:0] shadow_capacity;

  access_t  pending_accesses[$];
  outcome_t expected_outcomes[$];
  word_t    key_pool[$];

  int  error_count;
  int  responses_seen;
  bit  sender_gaps;
  bit  receiver_gaps;
  bit  long_hold_done;
  int  send_gap_left;
  int  recv_stall_left;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  function automatic void touch_entry(int i);
    if (shadow_count[i] != COUNT_MAX) shadow_count[i] = shadow_count[i] + 1'b1;
    shadow_stamp[i] = shadow_clock;
    shadow_clock    = shadow_clock + 1'b1;
  endfunction

  function automatic int lfu_victim();
    int best;
    best = -1;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      if (shadow_valid[i] && (best < 0 || shadow_count[i] < shadow_count[best] ||
          (shadow_count[i] == shadow_count[best] && shadow_stamp[i] < shadow_stamp[best])))
        best = i;
    end
    return best;
  endfunction

  function automatic outcome_t predict_cache_access(opcode_t op, word_t key, word_t value);
    outcome_t    o;
    int          slot;
    int          dst;
    int unsigned limit;
    slot = -1;
    dst  = -1;
    for (int i = 0; i < MAX_ENTRIES; i++)
      if (slot < 0 && shadow_valid[i] && shadow_key[i] == key) slot = i;
    limit     = (shadow_capacity > MAX_ENTRIES) ? MAX_ENTRIES : shadow_capacity;
    o.hit     = (slot >= 0);
    o.value   = '0;
    o.evicted = 1'b0;
    if (op == OP_GET) begin
      if (slot >= 0) begin
        o.value = shadow_value[slot];
        touch_entry(slot);
      end else begin
        o.value = '1;
      end
    end else if (limit != 0) begin
      if (slot >= 0) begin
        shadow_value[slot] = value;
        touch_entry(slot);
      end else begin
        if (shadow_fill >= limit) begin
          dst       = lfu_victim();
          o.evicted = 1'b1;
        end else begin
          for (int i = MAX_ENTRIES - 1; i >= 0; i--)
            if (!shadow_valid[i]) dst = i;
          if (dst >= 0) shadow_fill++;
        end
        if (dst < 0) begin
          dst       = lfu_victim();
          o.evicted = 1'b1;
        end
        if (dst >= 0) begin
          shadow_valid[dst] = 1'b1;
          shadow_key[dst]   = key;
          shadow_value[dst] = value;
          shadow_count[dst] = 1;
          shadow_stamp[dst] = shadow_clock;
          shadow_clock      = shadow_clock + 1'b1;
        end else begin
          o.evicted = 1'b0;
        end
      end
    end
    return o;
  endfunction

  // Request driver
  always @(posedge clk) begin
    access_t a;
    bit      holding;
    if (rst) begin
      req.valid     <= 1'b0;
      send_gap_left  = 0;
    end else begin
      if (req.valid && req.ready)
        expected_outcomes.push_back(predict_cache_access(opcode_t'(req.opcode),
                                                         req.lookup_key, req.write_value));
      holding = req.valid && !req.ready;
      if (!holding) begin
        if (send_gap_left > 0) begin
          send_gap_left--;
          req.valid <= 1'b0;
        end else if (pending_accesses.size() > 0) begin
          a = pending_accesses.pop_front();
          req.valid       <= 1'b1;
          req.opcode      <= a.op;
          req.lookup_key  <= a.key;
          req.write_value <= a.value;
          send_gap_left    = sender_gaps ? $urandom_range(0, 6) : 0;
        end else begin
          req.valid <= 1'b0;
        end
      end
    end
  end

  // Response monitor
  always @(posedge clk) begin
    outcome_t e;
    if (rst) begin
      rsp.ready      <= 1'b0;
      recv_stall_left = 0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (expected_outcomes.size() == 0) begin
          $display("%0t: unexpected response beat hit=%0b read_value=%h evicted=%0b",
                   $time, rsp.hit, rsp.read_value, rsp.evicted);
          error_count++;
        end else begin
          e = expected_outcomes.pop_front();
          if (rsp.hit !== e.hit) begin
            $display("%0t: hit mismatch expected %0b actual %0b", $time, e.hit, rsp.hit);
            error_count++;
          end
          if (rsp.read_value !== e.value) begin
            $display("%0t: read_value mismatch expected %h actual %h",
                     $time, e.value, rsp.read_value);
            error_count++;
          end
          if (rsp.evicted !== e.evicted) begin
            $display("%0t: evicted mismatch expected %0b actual %0b",
                     $time, e.evicted, rsp.evicted);
            error_count++;
          end
        end
        responses_seen++;
        recv_stall_left = receiver_gaps ? $urandom_range(0, 6) : 0;
        // hold off long enough for the request side to back up
        if (responses_seen == 400 && !long_hold_done) begin
          recv_stall_left = 300;
          long_hold_done  = 1'b1;
        end
      end else if (recv_stall_left > 0) begin
        recv_stall_left--;
      end
      rsp.ready <= (recv_stall_left == 0);
    end
  end

  task automatic wait_for_drain();
    while (pending_accesses.size() != 0 || req.valid || expected_outcomes.size() != 0)
      @(posedge clk);
  endtask

  task automatic write_capacity(logic [CAP_W-1:0] v);
    wait_for_drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    shadow_capacity = v;
    cfg_we <= 1'b0;
  endtask

  task automatic push_access(opcode_t op, word_t key, word_t value);
    access_t a;
    a.op    = op;
    a.key   = key;
    a.value = value;
    pending_accesses.push_back(a);
  endtask

  task automatic random_phase(int n, int pool_size, bit s_gaps, bit r_gaps);
    word_t k;
    sender_gaps   = s_gaps;
    receiver_gaps = r_gaps;
    key_pool.delete();
    key_pool.push_back(32'h0000_0000);
    key_pool.push_back(32'hFFFF_FFFF);
    key_pool.push_back(32'h8000_0000);
    key_pool.push_back(32'h7FFF_FFFF);
    while (key_pool.size() < pool_size)
      key_pool.push_back(($urandom_range(0, 1) == 0) ? $urandom() : $urandom_range(0, 63));
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < 85) k = key_pool[$urandom_range(0, pool_size - 1)];
      else k = $urandom();
      push_access(($urandom_range(0, 99) < 45) ? OP_PUT : OP_GET, k, $urandom());
    end
  endtask

  initial begin
    rst             = 1'b1;
    cfg_we          = 1'b0;
    cfg_wdata       = '0;
    req.valid       = 1'b0;
    req.opcode      = OP_GET;
    req.lookup_key  = '0;
    req.write_value = '0;
    rsp.ready       = 1'b0;
    error_count     = 0;
    responses_seen  = 0;
    long_hold_done  = 1'b0;
    sender_gaps     = 1'b0;
    receiver_gaps   = 1'b0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      shadow_valid[i] = 1'b0;
      shadow_key[i]   = '0;
      shadow_value[i] = '0;
      shadow_count[i] = '0;
      shadow_stamp[i] = '0;
    end
    shadow_clock    = '0;
    shadow_fill     = 0;
    shadow_capacity = CAP_RESET;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty lookups, extreme keys and values, update, hits
    push_access(OP_GET, 32'h0000_0000, 32'h1234_5678);
    push_access(OP_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
    push_access(OP_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
    push_access(OP_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_access(OP_PUT, 32'h0000_0000, 32'h0000_0000);
    push_access(OP_GET, 32'h7FFF_FFFF, 32'h0000_0000);
    push_access(OP_GET, 32'h8000_0000, 32'hFFFF_FFFF);
    push_access(OP_GET, 32'hFFFF_FFFF, 32'h0000_0000);
    push_access(OP_GET, 32'h0000_0000, 32'hFFFF_FFFF);
    push_access(OP_PUT, 32'h0000_0000, 32'hA5A5_5A5A);
    push_access(OP_GET, 32'h0000_0000, 32'h0000_0000);
    push_access(OP_GET, 32'h0000_0001, 32'h0000_0000);
    wait_for_drain();
    // Capacity one: each new key evicts the least frequently used entry
    write_capacity(5'd1);
    push_access(OP_PUT, 32'h0000_0011, 32'h0000_0001);
    push_access(OP_PUT, 32'h0000_0022, 32'h0000_0002);
    push_access(OP_GET, 32'h0000_0011, 32'h0000_0000);
    // Capacity zero: puts ignored, hits still reported
    write_capacity(5'd0);
    push_access(OP_PUT, 32'h0000_0033, 32'h0000_0003);
    push_access(OP_PUT, 32'h7FFF_FFFF, 32'h0000_0004);
    push_access(OP_GET, 32'h0000_0033, 32'h0000_0000);
    write_capacity(5'd16);

    random_phase(300, 24, 1'b1, 1'b1);
    write_capacity(5'd4);
    random_phase(200, 8, 1'b0, 1'b1);
    write_capacity(5'd0);
    random_phase(100, 12, 1'b1, 1'b0);
    write_capacity(5'd31);
    random_phase(200, 40, 1'b0, 1'b0);
    write_capacity(5'd1);
    random_phase(150, 4, 1'b1, 1'b1);
    write_capacity(5'd17);
    random_phase(150, 22, 1'b1, 1'b0);
    write_capacity(5'd16);
    random_phase(200, 20, 1'b0, 1'b1);
    write_capacity(5'd2);
    random_phase(150, 6, 1'b1, 1'b1);

    wait_for_drain();
    repeat (30) @(posedge clk);
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
